@@ hw/rtl/qte_pkg.sv @@
// qte_pkg: shared constants, types and the arctangent table for the
// quaternion to euler angle pipeline. no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

  localparam int AngW   = 24;
  localparam int ArgW   = 34;
  localparam int TabLen = 24;

  localparam logic signed [AngW-1:0] AngPi   = 24'sd3294199;
  localparam logic signed [AngW-1:0] AngPi2  = 24'sd1647099;
  localparam logic signed [13:0]     OutPi2  = 14'sd6434;

  localparam logic [2:0] RegGimbalThreshold = 3'd0;

  typedef struct packed {
    logic signed [31:0]     s;
    logic signed [ArgW-1:0] ygy;
    logic signed [ArgW-1:0] ygx;
    logic signed [ArgW-1:0] yny;
    logic signed [ArgW-1:0] ynx;
    logic signed [ArgW-1:0] rly;
    logic signed [ArgW-1:0] rlx;
  } args_t;

  function automatic logic signed [AngW-1:0] atan_tab(input int idx);
    logic signed [AngW-1:0] v;
    case (idx)
      0:  v = 24'sd823550;
      1:  v = 24'sd486170;
      2:  v = 24'sd256879;
      3:  v = 24'sd130396;
      4:  v = 24'sd65451;
      5:  v = 24'sd32757;
      6:  v = 24'sd16383;
      7:  v = 24'sd8192;
      8:  v = 24'sd4096;
      9:  v = 24'sd2048;
      10: v = 24'sd1024;
      11: v = 24'sd512;
      12: v = 24'sd256;
      13: v = 24'sd128;
      14: v = 24'sd64;
      15: v = 24'sd32;
      16: v = 24'sd16;
      17: v = 24'sd8;
      18: v = 24'sd4;
      19: v = 24'sd2;
      20: v = 24'sd1;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] to_out(input logic signed [AngW-1:0] a);
    logic signed [AngW-1:0] t;
    t = (a + 24'sd128) >>> 8;
    return t[15:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/qte_cordic.sv @@
// qte_cordic: pipelined vectoring cordic, atan2(y, x) at scale 2^20,
// clamped to [-pi, pi]. depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic #(
  parameter int CORDIC_STAGES = 14
) (
  input  wire                                  clk_i,
  input  wire                                  en_i,
  input  wire  signed [qte_pkg::ArgW-1:0]      y_i,
  input  wire  signed [qte_pkg::ArgW-1:0]      x_i,
  output logic signed [qte_pkg::AngW-1:0]      z_o
);
  localparam int Nst = (CORDIC_STAGES < qte_pkg::TabLen) ? CORDIC_STAGES : qte_pkg::TabLen;
  localparam int Xw  = qte_pkg::ArgW + 3;

  logic signed [Xw-1:0]            x_q [0:Nst];
  logic signed [Xw-1:0]            y_q [0:Nst];
  logic signed [qte_pkg::AngW-1:0] z_q [0:Nst];
  logic                            zero_q [0:Nst];
  logic signed [qte_pkg::AngW-1:0] res_q;

  // quadrant fold
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0] <= -Xw'(x_i);
        y_q[0] <= -Xw'(y_i);
        z_q[0] <= (y_i >= 0) ? qte_pkg::AngPi : -qte_pkg::AngPi;
      end else begin
        x_q[0] <= Xw'(x_i);
        y_q[0] <= Xw'(y_i);
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < Nst; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + qte_pkg::atan_tab(i);
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - qte_pkg::atan_tab(i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zero_q[Nst]) begin
        res_q <= '0;
      end else if (z_q[Nst] > qte_pkg::AngPi) begin
        res_q <= qte_pkg::AngPi;
      end else if (z_q[Nst] < -qte_pkg::AngPi) begin
        res_q <= -qte_pkg::AngPi;
      end else begin
        res_q <= z_q[Nst];
      end
    end
  end

  assign z_o = res_q;

endmodule
`default_nettype wire

@@ hw/rtl/quaternion_to_euler_angles.sv @@
// quaternion_to_euler_angles: zyx euler angles from a q1.15 quaternion stream.
// one beat per cycle while the output beat is not stalled.
// the pipeline advances as a whole and holds while the output beat is stalled.
// pitch path: products, sum, square, 31-stage square root, then cordic.
// reset clears valid bits and sets gimbal_threshold to 1; data regs not reset.
// depends on qte_pkg and qte_cordic.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles #(
  parameter int QUAT_WIDTH    = 16,
  parameter int CORDIC_STAGES = 14
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // quat_x, quat_y, quat_z, quat_w, zero pad
  input  wire  [((4*QUAT_WIDTH+7)/8)*8-1:0]   s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire                                 m_axis_tready_i,
  // roll_angle[14:0], pitch_angle[28:15], yaw_angle[44:29], zero pad
  output logic [47:0]                         m_axis_tdata_o,
  // gimbal_lock
  output logic                                m_axis_tuser_o,
  input  wire                                 psel_i,
  input  wire                                 penable_i,
  input  wire                                 pwrite_i,
  input  wire  [2:0]                          paddr_i,
  input  wire  [31:0]                         pwdata_i,
  output logic [31:0]                         prdata_o,
  output logic                                pready_o
);
  localparam int Nst  = (CORDIC_STAGES < qte_pkg::TabLen) ? CORDIC_STAGES : qte_pkg::TabLen;
  localparam int Lat  = Nst + 40;
  localparam int Dly  = 33;
  localparam int AW   = qte_pkg::ArgW;

  logic        en;
  logic [Lat-1:0] v_q;
  logic [12:0] thr_q;

  assign en              = !v_q[Lat-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = v_q[Lat-1];
  assign pready_o        = 1'b1;
  assign prdata_o        = ((paddr_i >> 2) == qte_pkg::RegGimbalThreshold) ?
                           {19'd0, thr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      thr_q <= 13'd1;
    end else begin
      if (en) begin
        v_q <= {v_q[Lat-2:0], s_axis_tvalid_i};
      end
      if (psel_i && penable_i && pwrite_i &&
          ((paddr_i >> 2) == qte_pkg::RegGimbalThreshold)) begin
        thr_q <= pwdata_i[12:0];
      end
    end
  end

  // input conversion to q1.15
  logic signed [15:0] qc [0:3];
  logic signed [15:0] q_q [0:3];
  for (genvar k = 0; k < 4; k++) begin : g_conv
    logic signed [QUAT_WIDTH-1:0] raw;
    assign raw = s_axis_tdata_i[k*QUAT_WIDTH +: QUAT_WIDTH];
    if (QUAT_WIDTH >= 16) begin : g_wide
      logic signed [QUAT_WIDTH-1:0] sh;
      assign sh    = raw >>> (QUAT_WIDTH - 16);
      assign qc[k] = sh[15:0];
    end else begin : g_narrow
      assign qc[k] = {raw, {(16-QUAT_WIDTH){1'b0}}};
    end
    always_ff @(posedge clk_i) begin
      if (en) q_q[k] <= qc[k];
    end
  end

  // products
  logic signed [31:0] wy_q, xz_q, yz_q, xw_q, xy_q, wz_q, xx_q, yy_q, zz_q, ww_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      wy_q <= q_q[3] * q_q[1];
      xz_q <= q_q[0] * q_q[2];
      yz_q <= q_q[1] * q_q[2];
      xw_q <= q_q[0] * q_q[3];
      xy_q <= q_q[0] * q_q[1];
      wz_q <= q_q[3] * q_q[2];
      xx_q <= q_q[0] * q_q[0];
      yy_q <= q_q[1] * q_q[1];
      zz_q <= q_q[2] * q_q[2];
      ww_q <= q_q[3] * q_q[3];
    end
  end

  // sums and asin argument clamp
  logic signed [AW-1:0] s_raw;
  qte_pkg::args_t       args_q;
  assign s_raw = (AW'(wy_q) - AW'(xz_q)) <<< 1;
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (s_raw > AW'(34'sd1073741824)) begin
        args_q.s <= 32'sd1073741824;
      end else if (s_raw < -AW'(34'sd1073741824)) begin
        args_q.s <= -32'sd1073741824;
      end else begin
        args_q.s <= s_raw[31:0];
      end
      args_q.ygy <= (AW'(yz_q) - AW'(xw_q)) <<< 1;
      args_q.ygx <= (AW'(xz_q) + AW'(wy_q)) <<< 1;
      args_q.yny <= (AW'(xy_q) + AW'(wz_q)) <<< 1;
      args_q.ynx <= AW'(xx_q) - AW'(yy_q) - AW'(zz_q) + AW'(ww_q);
      args_q.rly <= (AW'(xw_q) + AW'(yz_q)) <<< 1;
      args_q.rlx <= AW'(ww_q) - AW'(xx_q) - AW'(yy_q) + AW'(zz_q);
    end
  end

  qte_pkg::args_t dl_q [0:Dly-1];
  always_ff @(posedge clk_i) begin
    if (en) dl_q[0] <= args_q;
  end
  for (genvar j = 1; j < Dly; j++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en) dl_q[j] <= dl_q[j-1];
    end
  end

  // cosine of pitch: floor sqrt(2^60 - s^2), one root bit per stage
  logic [61:0] sq_q;
  logic [60:0] rem_q  [0:31];
  logic [30:0] root_q [0:31];
  logic signed [63:0] sq_full;
  assign sq_full = args_q.s * args_q.s;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q      <= sq_full[61:0];
      rem_q[0]  <= 61'(62'h1000_0000_0000_0000 - sq_q);
      root_q[0] <= '0;
    end
  end
  for (genvar j = 0; j < 31; j++) begin : g_sqrt
    localparam int K = 30 - j;
    logic [61:0] trial;
    assign trial = ({31'd0, root_q[j]} << (K + 1)) + (62'd1 << (2 * K));
    always_ff @(posedge clk_i) begin
      if (en) begin
        if ({1'b0, rem_q[j]} >= trial) begin
          rem_q[j+1]  <= 61'({1'b0, rem_q[j]} - trial);
          root_q[j+1] <= root_q[j] | (31'd1 << K);
        end else begin
          rem_q[j+1]  <= rem_q[j];
          root_q[j+1] <= root_q[j];
        end
      end
    end
  end

  logic signed [qte_pkg::AngW-1:0] pa, yga, yna, rla;
  qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk_i(clk_i), .en_i(en),
    .y_i(AW'(dl_q[Dly-1].s)), .x_i(AW'({3'd0, root_q[31]})), .z_o(pa));
  qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw_g (
    .clk_i(clk_i), .en_i(en),
    .y_i(dl_q[Dly-1].ygy), .x_i(dl_q[Dly-1].ygx), .z_o(yga));
  qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw_n (
    .clk_i(clk_i), .en_i(en),
    .y_i(dl_q[Dly-1].yny), .x_i(dl_q[Dly-1].ynx), .z_o(yna));
  qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk_i(clk_i), .en_i(en),
    .y_i(dl_q[Dly-1].rly), .x_i(dl_q[Dly-1].rlx), .z_o(rla));

  // rounding
  logic signed [qte_pkg::AngW-1:0] pcl;
  logic signed [15:0] p_full;
  logic signed [13:0] po_q;
  logic signed [15:0] ygo_q, ygr_q, yno_q;
  logic signed [14:0] rlo_q;
  logic signed [15:0] rl_full;
  assign pcl = (pa > qte_pkg::AngPi2) ? qte_pkg::AngPi2 :
               ((pa < -qte_pkg::AngPi2) ? -qte_pkg::AngPi2 : pa);
  assign p_full  = qte_pkg::to_out(pcl);
  assign rl_full = qte_pkg::to_out(rla);
  always_ff @(posedge clk_i) begin
    if (en) begin
      po_q  <= p_full[13:0];
      ygo_q <= qte_pkg::to_out(yga);
      ygr_q <= qte_pkg::to_out(qte_pkg::AngPi - yga);
      yno_q <= qte_pkg::to_out(yna);
      rlo_q <= rl_full[14:0];
    end
  end

  // gimbal branch select
  logic signed [13:0] pabs;
  logic        [13:0] margin;
  logic               lock;
  assign pabs   = (po_q < 0) ? -po_q : po_q;
  assign margin = 14'(qte_pkg::OutPi2 - pabs);
  assign lock   = margin < {1'b0, thr_q};
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tuser_o        <= lock;
      m_axis_tdata_o[47:45] <= '0;
      m_axis_tdata_o[28:15] <= po_q;
      if (lock) begin
        m_axis_tdata_o[14:0]  <= '0;
        m_axis_tdata_o[44:29] <= (po_q < 0) ? ygr_q : ygo_q;
      end else begin
        m_axis_tdata_o[14:0]  <= rlo_q;
        m_axis_tdata_o[44:29] <= yno_q;
      end
    end
  end

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("ready does not follow output stall");
  a_lock_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[14:0] == 15'd0))
    else $error("roll not zero in gimbal branch");
  a_pitch_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[28:15]) <= 14'sd6434 &&
                         $signed(m_axis_tdata_o[28:15]) >= -14'sd6434))
    else $error("pitch out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule
`default_nettype wire

@@ dv/qte_checker.sv @@
// qte_checker: watches the quaternion input and euler angle output streams
// and the apb port, predicts every output beat and compares it field by field.
// depends on qte_pkg for the register index.
`timescale 1ns / 1ps
module qte_checker (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_tvalid_i,
  input  wire          s_tready_i,
  input  wire  [63:0]  s_tdata_i,
  input  wire          m_tvalid_i,
  input  wire          m_tready_i,
  input  wire  [47:0]  m_tdata_i,
  input  wire          m_tuser_i,
  input  wire          psel_i,
  input  wire          penable_i,
  input  wire          pwrite_i,
  input  wire          pready_i,
  input  wire  [2:0]   paddr_i,
  input  wire  [31:0]  pwdata_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    logic signed [14:0] roll;
    logic signed [13:0] pitch;
    logic signed [15:0] yaw;
    logic               lock;
  } euler_t;

  localparam int Stages = 14;
  localparam longint RadPi = 3294199;
  localparam longint RadPi2 = 1647099;
  localparam longint OutQuarter = 6434;
  localparam longint ArcTab [0:20] = '{823550, 486170, 256879, 130396, 65451, 32757,
    16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

  euler_t angles_q[$];
  longint lock_thresh;
  int     fails;

  assign fail_count_o = fails;
  assign pending_o    = angles_q.size();

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint ang, dx, dy;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      ang = (y >= 0) ? RadPi : -RadPi;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < Stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        ang = ang + ArcTab[i];
      end else begin
        x = x - dx;
        y = y + dy;
        ang = ang - ArcTab[i];
      end
    end
    return clip(ang, -RadPi, RadPi);
  endfunction

  function automatic longint round_out(longint a);
    return (a + 128) >>> 8;
  endfunction

  function automatic euler_t predict_angles(logic [63:0] d, longint thr);
    longint x, y, z, w, s, c, p, po, margin, ya;
    euler_t e;
    x = longint'($signed(d[15:0]));
    y = longint'($signed(d[31:16]));
    z = longint'($signed(d[47:32]));
    w = longint'($signed(d[63:48]));
    s = clip(2 * (w * y - x * z), -(64'sd1 << 30), 64'sd1 << 30);
    c = root_floor((64'd1 << 60) - longint'(s * s));
    p = clip(vector_angle(s, c), -RadPi2, RadPi2);
    po = round_out(p);
    margin = OutQuarter - (po < 0 ? -po : po);
    e.pitch = po[13:0];
    if (margin < thr) begin
      e.lock = 1'b1;
      e.roll = '0;
      ya = vector_angle(2 * (y * z - x * w), 2 * (x * z + y * w));
      if (po < 0) ya = RadPi - ya;
      ya = round_out(ya);
      e.yaw = ya[15:0];
    end else begin
      e.lock = 1'b0;
      ya = round_out(vector_angle(2 * (x * y + w * z), x * x - y * y - z * z + w * w));
      e.yaw = ya[15:0];
      ya = round_out(vector_angle(2 * (w * x + y * z), w * w - x * x - y * y + z * z));
      e.roll = ya[14:0];
    end
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    euler_t exp_e, got_e;
    if (!rst_ni) begin
      lock_thresh = 1;
      fails = 0;
      angles_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          (paddr_i >> 2) == qte_pkg::RegGimbalThreshold)
        lock_thresh = longint'(pwdata_i[12:0]);
      if (s_tvalid_i && s_tready_i)
        angles_q.push_back(predict_angles(s_tdata_i, lock_thresh));
      if (m_tvalid_i && m_tready_i) begin
        got_e.roll  = m_tdata_i[14:0];
        got_e.pitch = m_tdata_i[28:15];
        got_e.yaw   = m_tdata_i[44:29];
        got_e.lock  = m_tuser_i;
        if (angles_q.size() == 0) begin
          $error("output beat with nothing expected");
          fails++;
        end else begin
          exp_e = angles_q.pop_front();
          if (got_e.roll !== exp_e.roll) begin
            $error("roll_angle expected %0d got %0d", exp_e.roll, got_e.roll);
            fails++;
          end
          if (got_e.pitch !== exp_e.pitch) begin
            $error("pitch_angle expected %0d got %0d", exp_e.pitch, got_e.pitch);
            fails++;
          end
          if (got_e.yaw !== exp_e.yaw) begin
            $error("yaw_angle expected %0d got %0d", exp_e.yaw, got_e.yaw);
            fails++;
          end
          if (got_e.lock !== exp_e.lock) begin
            $error("gimbal_lock expected %0d got %0d", exp_e.lock, got_e.lock);
            fails++;
          end
        end
      end
    end
  end

endmodule

@@ dv/testbench.sv @@
// testbench: drives quaternion beats and apb threshold writes into
// quaternion_to_euler_angles; qte_checker predicts and compares the outputs.
`timescale 1ns / 1ps
module testbench;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  bit          tx_quiet;
  bit          rx_quiet;
  bit          rx_took;
  int          rx_hold;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  quaternion_to_euler_angles dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata),
    .m_axis_tuser_o(m_tuser),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_o(prdata), .pready_o(pready)
  );

  qte_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .m_tuser_i(m_tuser),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // output side back-pressure
  always @(posedge clk) rx_took <= m_tvalid && m_tready;

  always @(negedge clk) begin
    if (!rst_n) begin
      rx_hold = 0;
    end else begin
      if (rx_took) rx_hold = rx_quiet ? 0 : $urandom_range(0, 5);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_quat(input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z, input logic [15:0] w);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {w, z, y, x};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [15:0] jitter(int base, int span);
    return 16'(base + $urandom_range(0, 2 * span) - span);
  endfunction

  task automatic send_random();
    int sel, a, sg;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else if (sel < 82) begin
      // near vertical pitch, w close to +-y
      a  = $urandom_range(19000, 23500);
      sg = $urandom_range(0, 1) ? a : -a;
      send_quat(jitter(0, 700), jitter(sg, 300), jitter(0, 700),
                jitter($urandom_range(0, 1) ? a : -a, 300));
    end else begin
      send_quat(jitter(0, 40), jitter(0, 40), jitter(0, 40), jitter(0, 40));
    end
  endtask

  initial begin
    int thresholds [6];
    thresholds = '{0, 6434, 8191, 300, 20, 0};
    thresholds[5] = $urandom_range(0, 6434);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset threshold
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7fff);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_quat(16'h0000, 16'h5a82, 16'h0000, 16'h5a82);
    send_quat(16'h0000, 16'ha57e, 16'h0000, 16'h5a82);
    send_quat(16'h1000, 16'h5a00, 16'h0800, 16'h5a82);
    send_quat(16'h1000, 16'ha600, 16'hf800, 16'h5a82);
    send_quat(16'h7fff, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h7fff, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h7fff, 16'h8000);
    send_quat(16'h8000, 16'h0000, 16'h0000, 16'h1000);
    send_quat(16'h4000, 16'h4000, 16'h4000, 16'h4000);
    send_quat(16'hc000, 16'h4000, 16'hc000, 16'h4000);
    send_quat(16'h0001, 16'hffff, 16'h0001, 16'hffff);
    drain_outputs();

    // an unknown register index must leave the threshold alone
    apb_write(3'd4, 32'd0);

    for (int ph = 0; ph < 6; ph++) begin
      apb_write(3'(qte_pkg::RegGimbalThreshold << 2), 32'(thresholds[ph]));
      if (ph == 1) send_quat(16'h0000, 16'h5a82, 16'h0000, 16'h5a82);
      for (int n = 0; n < 140; n++) begin
        tx_quiet = (n >= 40 && n < 70);
        rx_quiet = (n >= 50 && n < 80);
        if (n == 100) drain_outputs();
        send_random();
      end
      drain_outputs();
    end

    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ quaternion_to_euler_angles.f @@
hw/rtl/qte_pkg.sv
hw/rtl/qte_cordic.sv
hw/rtl/quaternion_to_euler_angles.sv
dv/qte_checker.sv
dv/testbench.sv
